[rtl/ppc_pkg.sv]
`timescale 1ns / 1ps
// Package for the prime/perfect classifier: widths, result structs of the
// serial divider and multiplier. No dependencies.
package ppc_pkg;

  localparam int VALUE_BITS = 32;
  localparam int IN_W       = 32;
  localparam int NUM_W      = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;
  localparam int DIV_W      = NUM_W / 2 + 1;
  localparam int SQ_W       = NUM_W + 2;
  localparam int SUM_W      = 40;
  localparam int CNT_W      = 32;
  localparam int WIDE_W     = 64;
  localparam int STEP_W     = $clog2(NUM_W + 1);

  typedef struct packed {
    logic             done;
    logic             rem_zero;
    logic [NUM_W-1:0] quo;
  } div_res_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [WIDE_W-1:0] prod;
  } mul_res_t;

endpackage

[rtl/ppc_in_if.sv]
`timescale 1ns / 1ps
// Input channel of the classifier: valid/ready plus the number and clear flag.
// Depends on ppc_pkg.
interface ppc_in_if import ppc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] value;
  logic            clear_stats;

  modport source (output valid, value, clear_stats, input ready);
  modport sink   (input valid, value, clear_stats, output ready);
endinterface

[rtl/ppc_out_if.sv]
`timescale 1ns / 1ps
// Result channel of the classifier: valid/ready plus flags and statistics.
// Depends on ppc_pkg.
interface ppc_out_if import ppc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_prime;
  logic              is_perfect;
  logic [CNT_W-1:0]  prime_count;
  logic [WIDE_W-1:0] prime_product;
  logic              product_overflow;
  logic [CNT_W-1:0]  perfect_count;
  logic [WIDE_W-1:0] perfect_sum;

  modport source (output valid, is_prime, is_perfect, prime_count, prime_product,
                  product_overflow, perfect_count, perfect_sum, input ready);
  modport sink   (input valid, is_prime, is_perfect, prime_count, prime_product,
                  product_overflow, perfect_count, perfect_sum, output ready);
endinterface

[rtl/ppc_div.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ppc_pkg.
module ppc_div import ppc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output div_res_t         res
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [NUM_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dsr_r, dsr_nxt;
  logic [DIV_W:0]    trial;
  logic [DIV_W-1:0]  diff;
  logic              fits;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial[DIV_W-1:0] - dsr_r;
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[NUM_W-2:0], fits};
      rem_nxt  = fits ? diff : trial[DIV_W-1:0];
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign res.done     = done_r;
  assign res.rem_zero = (rem_r == '0);
  assign res.quo      = quo_r;

endmodule

[rtl/ppc_mul.sv]
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, WIDE_W x NUM_W, one multiplier bit per cycle.
// Reports the low WIDE_W product bits and overflow. Depends on ppc_pkg.
module ppc_mul import ppc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WIDE_W-1:0] mcand,
  input  logic [NUM_W-1:0]  mplier,
  output mul_res_t          res
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [WIDE_W-1:0] a_r, a_nxt;
  logic [WIDE_W-1:0] hi_r, hi_nxt;
  logic [NUM_W-1:0]  lo_r, lo_nxt;
  logic [WIDE_W:0]   add;

  assign add = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      a_nxt    = mcand;
      hi_nxt   = '0;
      lo_nxt   = mplier;
    end else if (busy_r) begin
      hi_nxt   = add[WIDE_W:1];
      lo_nxt   = {add[0], lo_r[NUM_W-1:1]};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign res.done = done_r;
  assign res.ovf  = |hi_r[WIDE_W-1:WIDE_W-NUM_W];
  assign res.prod = {hi_r[WIDE_W-NUM_W-1:0], lo_r};

endmodule

[rtl/prime_perfect_classifier.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Payload
// in_ch    in   valid/ready        value[31:0], clear_stats
// out_ch   out  valid/ready        is_prime, is_perfect, prime_count, prime_product,
//                                  product_overflow, perfect_count, perfect_sum
// One item at a time. Trial divisors d = 2.. while d*d <= value, each through the
// serial divider; a prime then goes through the serial multiplier unless the
// product is already saturated. Reset: counts and sum 0, product 1, no overflow.
// A held result does not block the next item; finishing waits for out_ch to drain.
// Top level: FSM, divisor loop, statistics. Depends on ppc_pkg, ppc_in_if,
// ppc_out_if, ppc_div, ppc_mul.
module prime_perfect_classifier import ppc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  ppc_in_if.sink           in_ch,
  ppc_out_if.source        out_ch
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOP = 6'b000010,
    S_DIV  = 6'b000100,
    S_POST = 6'b001000,
    S_MUL  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NUM_W-1:0]  n_r, n_nxt;
  logic [DIV_W-1:0]  d_r, d_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              found_r, found_nxt;
  logic              prime_r, prime_nxt;
  logic              perfect_r, perfect_nxt;
  logic [CNT_W-1:0]  primes_seen_r, primes_seen_nxt;
  logic [WIDE_W-1:0] prime_prod_r, prime_prod_nxt;
  logic              prod_sat_r, prod_sat_nxt;
  logic [CNT_W-1:0]  perfects_seen_r, perfects_seen_nxt;
  logic [WIDE_W-1:0] perfect_total_r, perfect_total_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              o_prime_r, o_perfect_r, o_sat_r;
  logic [CNT_W-1:0]  o_pcount_r, o_fcount_r;
  logic [WIDE_W-1:0] o_prod_r, o_total_r;

  logic              in_fire, out_fire, load_out;
  logic              loop_end, div_start, mul_start;
  logic              prime_w, perfect_w;
  logic [NUM_W-1:0]  in_num;
  logic [WIDE_W:0]   total_add;
  div_res_t          div_res;
  mul_res_t          mul_res;

  assign in_num    = in_ch.value[NUM_W-1:0];
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_valid_r && out_ch.ready;

  assign loop_end  = (n_r < NUM_W'(2)) || (sq_r > SQ_W'(n_r));
  assign div_start = (state_r == S_LOOP) && !loop_end;
  assign prime_w   = (n_r >= NUM_W'(2)) && !found_r;
  assign perfect_w = (n_r != '0) && (sum_r == SUM_W'(n_r));
  assign mul_start = (state_r == S_POST) && prime_w && !prod_sat_r;
  assign total_add = {1'b0, perfect_total_r} + (WIDE_W + 1)'(n_r);

  ppc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (d_r),
    .res      (div_res)
  );

  ppc_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (prime_prod_r),
    .mplier (n_r),
    .res    (mul_res)
  );

  always_comb begin
    state_nxt         = state_r;
    n_nxt             = n_r;
    d_nxt             = d_r;
    sq_nxt            = sq_r;
    sum_nxt           = sum_r;
    found_nxt         = found_r;
    prime_nxt         = prime_r;
    perfect_nxt       = perfect_r;
    primes_seen_nxt   = primes_seen_r;
    prime_prod_nxt    = prime_prod_r;
    prod_sat_nxt      = prod_sat_r;
    perfects_seen_nxt = perfects_seen_r;
    perfect_total_nxt = perfect_total_r;
    load_out          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          n_nxt     = in_num;
          d_nxt     = DIV_W'(2);
          sq_nxt    = SQ_W'(4);
          sum_nxt   = (in_num >= NUM_W'(2)) ? SUM_W'(1) : '0;
          found_nxt = 1'b0;
          if (in_ch.clear_stats) begin
            primes_seen_nxt   = '0;
            prime_prod_nxt    = WIDE_W'(1);
            prod_sat_nxt      = 1'b0;
            perfects_seen_nxt = '0;
            perfect_total_nxt = '0;
          end
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        state_nxt = loop_end ? S_POST : S_DIV;
      end
      S_DIV: begin
        if (div_res.done) begin
          if (div_res.rem_zero) begin
            found_nxt = 1'b1;
            sum_nxt   = sum_r + SUM_W'(d_r) +
                        ((div_res.quo != NUM_W'(d_r)) ? SUM_W'(div_res.quo) : '0);
          end
          d_nxt     = d_r + DIV_W'(1);
          sq_nxt    = sq_r + SQ_W'({d_r, 1'b1});
          state_nxt = S_LOOP;
        end
      end
      S_POST: begin
        prime_nxt   = prime_w;
        perfect_nxt = perfect_w;
        state_nxt   = S_DONE;
        if (prime_w) begin
          if (primes_seen_r != '1) primes_seen_nxt = primes_seen_r + CNT_W'(1);
          if (prod_sat_r) prime_prod_nxt = '1;
          else state_nxt = S_MUL;
        end
        if (perfect_w) begin
          if (perfects_seen_r != '1) perfects_seen_nxt = perfects_seen_r + CNT_W'(1);
          perfect_total_nxt = total_add[WIDE_W] ? '1 : total_add[WIDE_W-1:0];
        end
      end
      S_MUL: begin
        if (mul_res.done) begin
          if (mul_res.ovf) begin
            prime_prod_nxt = '1;
            prod_sat_nxt   = 1'b1;
          end else begin
            prime_prod_nxt = mul_res.prod;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_fire ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      d_r             <= '0;
      sum_r           <= '0;
      found_r         <= 1'b0;
      primes_seen_r   <= '0;
      prime_prod_r    <= WIDE_W'(1);
      prod_sat_r      <= 1'b0;
      perfects_seen_r <= '0;
      perfect_total_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      d_r             <= d_nxt;
      sum_r           <= sum_nxt;
      found_r         <= found_nxt;
      primes_seen_r   <= primes_seen_nxt;
      prime_prod_r    <= prime_prod_nxt;
      prod_sat_r      <= prod_sat_nxt;
      perfects_seen_r <= perfects_seen_nxt;
      perfect_total_r <= perfect_total_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    sq_r      <= sq_nxt;
    prime_r   <= prime_nxt;
    perfect_r <= perfect_nxt;
    if (load_out) begin
      o_prime_r   <= prime_r;
      o_perfect_r <= perfect_r;
      o_pcount_r  <= primes_seen_r;
      o_prod_r    <= prime_prod_r;
      o_sat_r     <= prod_sat_r;
      o_fcount_r  <= perfects_seen_r;
      o_total_r   <= perfect_total_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.is_prime         = o_prime_r;
  assign out_ch.is_perfect       = o_perfect_r;
  assign out_ch.prime_count      = o_pcount_r;
  assign out_ch.prime_product    = o_prod_r;
  assign out_ch.product_overflow = o_sat_r;
  assign out_ch.perfect_count    = o_fcount_r;
  assign out_ch.perfect_sum      = o_total_r;

  a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
    prod_sat_r |-> (prime_prod_r == '1))
    else $error("saturated product not at maximum");

  a_mul_only_prime: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> (n_r >= NUM_W'(2)) && !found_r)
    else $error("multiply started for a non-prime");

  a_div_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (d_r >= DIV_W'(2)) && (sq_r <= SQ_W'(n_r)))
    else $error("trial divisor out of range");

  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(o_prime_r && o_perfect_r))
    else $error("item flagged prime and perfect");

  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && (state_r == S_IDLE))
    else $error("result load lost");

endmodule

[dv/prime_perfect_classifier_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for prime_perfect_classifier: a directed pass, random numbers
// under four idle/stall mixes, and a long output hold-off.
// Depends on ppc_pkg, ppc_in_if, ppc_out_if and the classifier RTL.
module prime_perfect_classifier_tb;
  import ppc_pkg::*;

  typedef struct packed {
    logic              is_prime;
    logic              is_perfect;
    logic [CNT_W-1:0]  prime_count;
    logic [WIDE_W-1:0] prime_product;
    logic              product_overflow;
    logic [CNT_W-1:0]  perfect_count;
    logic [WIDE_W-1:0] perfect_sum;
  } verdict_t;

  localparam logic [WIDE_W-1:0] WIDE_MAX  = '1;
  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;

  logic clk;
  logic rst_n;

  ppc_in_if  in_ch ();
  ppc_out_if out_ch ();

  prime_perfect_classifier dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // running statistics mirrored from the block
  logic [CNT_W-1:0]  primes_tally;
  logic [WIDE_W-1:0] prime_prod_acc;
  logic              prod_saturated;
  logic [CNT_W-1:0]  perfects_tally;
  logic [WIDE_W-1:0] perfect_sum_acc;

  verdict_t pending_verdicts[$];
  int       mismatch_count;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400_000_000;
    $display("prime_perfect_classifier verification failed");
    $finish;
  end

  function automatic verdict_t classify_number(input logic [IN_W-1:0] raw, input logic clr);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    longint unsigned dsum;
    bit               prime;
    bit               perfect;
    verdict_t         r;
    n = 64'(raw[NUM_W-1:0]);
    if (clr) begin
      primes_tally    = '0;
      prime_prod_acc  = 64'd1;
      prod_saturated  = 1'b0;
      perfects_tally  = '0;
      perfect_sum_acc = '0;
    end
    prime = (n >= 2);
    dsum  = (n >= 2) ? 1 : 0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) begin
        prime = 1'b0;
        q     = n / d;
        dsum += d;
        if (q != d) dsum += q;
      end
    end
    dsum    = dsum & ((64'd1 << SUM_W) - 1);
    perfect = (n != 0) && (dsum == n);
    if (prime) begin
      if (primes_tally != COUNT_MAX) primes_tally++;
      if (prod_saturated) begin
        prime_prod_acc = WIDE_MAX;
      end else if (prime_prod_acc > WIDE_MAX / n) begin
        prime_prod_acc = WIDE_MAX;
        prod_saturated = 1'b1;
      end else begin
        prime_prod_acc = prime_prod_acc * n;
      end
    end
    if (perfect) begin
      if (perfects_tally != COUNT_MAX) perfects_tally++;
      if (perfect_sum_acc > WIDE_MAX - n) perfect_sum_acc = WIDE_MAX;
      else perfect_sum_acc = perfect_sum_acc + n;
    end
    r.is_prime         = prime;
    r.is_perfect       = perfect;
    r.prime_count      = primes_tally;
    r.prime_product    = prime_prod_acc;
    r.product_overflow = prod_saturated;
    r.perfect_count    = perfects_tally;
    r.perfect_sum      = perfect_sum_acc;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // accepted numbers -> expected verdicts
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      pending_verdicts.push_back(classify_number(in_ch.value, in_ch.clear_stats));
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("result with no number pending");
      end else begin
        want = pending_verdicts.pop_front();
        check_field("is_prime", 64'(want.is_prime), 64'(out_ch.is_prime));
        check_field("is_perfect", 64'(want.is_perfect), 64'(out_ch.is_perfect));
        check_field("prime_count", 64'(want.prime_count), 64'(out_ch.prime_count));
        check_field("prime_product", want.prime_product, out_ch.prime_product);
        check_field("product_overflow", 64'(want.product_overflow),
                    64'(out_ch.product_overflow));
        check_field("perfect_count", 64'(want.perfect_count), 64'(out_ch.perfect_count));
        check_field("perfect_sum", want.perfect_sum, out_ch.perfect_sum);
      end
    end
  end

  // output ready: long hold-off when requested, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_number(input logic [IN_W-1:0] value, input logic clr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.value       <= value;
    in_ch.clear_stats <= clr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] pick_number();
    logic [IN_W-1:0] perfects[4] = '{32'd6, 32'd28, 32'd496, 32'd8128};
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      6: return perfects[$urandom_range(0, 3)];
      7: return IN_W'($urandom_range(60000, 65535));
      8: return IN_W'($urandom_range(0, 1 << 20));
      9: return IN_W'($urandom_range(0, 15));
      default: return IN_W'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_number(32'd0, 1'b1);
    send_number(32'd1, 1'b0);
    send_number(32'd2, 1'b0);
    send_number(32'd3, 1'b0);
    send_number(32'd4, 1'b0);
    send_number(32'd6, 1'b0);
    send_number(32'd28, 1'b0);
    send_number(32'd496, 1'b0);
    send_number(32'd8128, 1'b0);
    send_number(32'd33550336, 1'b0);
    // 65521^5 runs past 2^64: product saturates and stays there
    send_number(32'd65521, 1'b1);
    repeat (4) send_number(32'd65521, 1'b0);
    send_number(32'd7, 1'b0);
    send_number(32'd12, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b0);
    send_number(32'd97, 1'b1);
    send_number(32'd1, 1'b1);
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_number(pick_number(), ($urandom_range(0, 19) == 0));
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 3000;
    repeat (8) send_number(IN_W'($urandom_range(2, 200)), 1'b0);
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.value       = '0;
    in_ch.clear_stats = 1'b0;
    out_ch.ready      = 1'b0;
    rst_n             = 1'b0;
    mismatch_count    = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_left         = 0;
    primes_tally      = '0;
    prime_prod_acc    = 64'd1;
    prod_saturated    = 1'b0;
    perfects_tally    = '0;
    perfect_sum_acc   = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(18, 0, 0);
    test_random(18, 63, 0);
    test_random(18, 0, 63);
    test_random(18, 18, 18);
    test_backpressure();
    in_ch.valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("prime_perfect_classifier verification clean");
    end else begin
      $display("prime_perfect_classifier verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ppc_pkg.sv
rtl/ppc_in_if.sv
rtl/ppc_out_if.sv
rtl/ppc_div.sv
rtl/ppc_mul.sv
rtl/prime_perfect_classifier.sv
dv/prime_perfect_classifier_tb.sv
